>>> sv/btwt_pkg.sv
// ----------------------------------------------------------------------------
// btwt_pkg
// Shared widths, types and constant functions for the balanced ternary
// weight term generator.
// ----------------------------------------------------------------------------
package btwt_pkg;

  localparam int unsigned VAL_W = 62;
  localparam int unsigned EXP_W = 6;
  localparam int unsigned RES_W = 64;

  typedef logic [VAL_W-1:0]        val_t;
  typedef logic [EXP_W-1:0]        exp_t;
  typedef logic signed [RES_W-1:0] res_t;

  // Token that walks down the row of digit cells.
  typedef struct packed {
    logic act;
    logic first;
    res_t res;
  } token_t;

  // What a cell reports in the current cycle; all zero unless it holds the token.
  typedef struct packed {
    logic act;
    logic term;
    logic done;
    logic minus;
    exp_t expo;
    val_t weight;
  } cell_ev_t;

  // Three raised to j, evaluated at elaboration only.
  function automatic val_t pow3(input int unsigned j);
    longint unsigned w;
    w = 64'd1;
    for (int unsigned k = 0; k < j; k++) begin
      w = w * 64'd3;
    end
    return val_t'(w);
  endfunction

endpackage

>>> sv/btwt_if.sv
// ----------------------------------------------------------------------------
// btwt_if
// Valid/ready stream interfaces for the input values and the result terms.
// ----------------------------------------------------------------------------
interface btwt_in_if import btwt_pkg::*;;
  logic valid;
  logic ready;
  val_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface btwt_out_if import btwt_pkg::*;;
  logic valid;
  logic ready;
  logic present;
  exp_t exponent;
  val_t weight;
  logic minus;
  logic last;

  modport source (output valid, output present, output exponent, output weight,
                  output minus, output last, input ready);
  modport sink   (input valid, input present, input exponent, input weight,
                  input minus, input last, output ready);
endinterface

>>> sv/btwt_cell.sv
// ----------------------------------------------------------------------------
// btwt_cell
// One digit position of the scan. Holds the residue token for its position,
// decides whether a term of weight 3^J is emitted and hands the updated
// residue to the next lower position.
// ----------------------------------------------------------------------------
module btwt_cell import btwt_pkg::*; #(
  parameter int unsigned J = 0
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  token_t   tok_i,
  output token_t   tok_o,
  output cell_ev_t ev_o
);

  localparam val_t W   = pow3(J);
  localparam val_t THR = W >> 1;
  localparam exp_t EXP = EXP_W'(J);

  logic act_q;
  logic first_q;
  res_t res_q;

  res_t             w_s;
  logic             zero;
  logic             neg;
  logic [RES_W-1:0] mag;
  logic             hit;
  res_t             res_nx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else if (en_i) begin
      act_q <= tok_i.act;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      first_q <= tok_i.first;
      res_q   <= tok_i.res;
    end
  end

  assign w_s  = res_t'({{(RES_W-VAL_W){1'b0}}, W});
  assign zero = (res_q == '0);
  assign neg  = res_q[RES_W-1];
  assign mag  = neg ? RES_W'(-res_q) : RES_W'(res_q);
  assign hit  = act_q && !zero && (mag > {{(RES_W-VAL_W){1'b0}}, THR});

  always_comb begin
    res_nx = res_q;
    if (hit) begin
      if (first_q) begin
        res_nx = w_s - res_q;
      end else if (neg) begin
        res_nx = res_q + w_s;
      end else begin
        res_nx = res_q - w_s;
      end
    end
  end

  // The token stops here once the residue has reached zero.
  assign tok_o.act   = act_q && !zero;
  assign tok_o.first = first_q && !hit;
  assign tok_o.res   = res_nx;

  assign ev_o.act    = act_q;
  assign ev_o.term   = hit;
  assign ev_o.done   = act_q && zero;
  assign ev_o.minus  = hit && !first_q && !neg;
  assign ev_o.expo   = hit ? EXP : '0;
  assign ev_o.weight = hit ? W : '0;

endmodule

>>> sv/balanced_ternary_weight_terms.sv
// ----------------------------------------------------------------------------
// balanced_ternary_weight_terms
// Expresses an unsigned value as a signed sum of powers of three, one
// result transaction per term, scanning from the top digit down.
// ----------------------------------------------------------------------------
//   channel  direction  payload                                 handshake
//   in_i     sink       value                                   valid/ready
//   out_o    source     present, exponent, weight, minus, last  valid/ready
//
// A value enters the top cell of a row of TOP_DIGIT+1 digit cells and moves
// down one position per cycle while the output is not stalled; the scan ends
// early when the residue reaches zero early, and the input is ready again
// from the cycle in which the last result is presented.
// One value is in flight at a time. Each term is held one step in a pending
// register so the final one can carry last. A stalled output freezes the row.
// Reset clears the token, busy and valid flags.
// ----------------------------------------------------------------------------
module balanced_ternary_weight_terms import btwt_pkg::*; #(
  parameter int unsigned TOP_DIGIT = 39
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  btwt_in_if.sink           in_i,
  btwt_out_if.source        out_o
);

  localparam int unsigned NCELL = TOP_DIGIT + 1;

  token_t   tok_out [NCELL];
  token_t   load_tok;
  cell_ev_t ev      [NCELL];
  cell_ev_t ev_or;
  logic [NCELL-1:0] act_vec;

  logic busy_q;
  logic tail_q;
  logic accept;
  logic advance;
  logic term;
  logic done;

  logic pend_v_q;
  exp_t pend_expo_q;
  val_t pend_weight_q;
  logic pend_minus_q;

  logic out_valid_q;
  logic out_present_q;
  exp_t out_expo_q;
  val_t out_weight_q;
  logic out_minus_q;
  logic out_last_q;

  assign accept  = in_i.valid && in_i.ready;
  assign advance = !out_valid_q || out_o.ready;
  assign in_i.ready = !busy_q;

  assign load_tok.act   = accept;
  assign load_tok.first = 1'b1;
  assign load_tok.res   = res_t'({{(RES_W-VAL_W){1'b0}}, in_i.value});

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    if (g == NCELL - 1) begin : g_top
      btwt_cell #(.J(g)) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (advance || accept),
        .tok_i  (load_tok),
        .tok_o  (tok_out[g]),
        .ev_o   (ev[g])
      );
    end else begin : g_mid
      btwt_cell #(.J(g)) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (advance),
        .tok_i  (tok_out[g+1]),
        .tok_o  (tok_out[g]),
        .ev_o   (ev[g])
      );
    end
    assign act_vec[g] = ev[g].act;
  end

  // Only the cell holding the token reports anything, so an OR merges them.
  always_comb begin
    ev_or = '0;
    for (int unsigned i = 0; i < NCELL; i++) begin
      ev_or = ev_or | ev[i];
    end
  end

  assign term = ev_or.term;
  assign done = ev_or.done || tail_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      tail_q      <= 1'b0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (advance && done) begin
        busy_q <= 1'b0;
      end
      if (advance) begin
        tail_q      <= tok_out[0].act;
        out_valid_q <= (term && pend_v_q) || done;
        if (term) begin
          pend_v_q <= 1'b1;
        end else if (done) begin
          pend_v_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (term) begin
        pend_expo_q   <= ev_or.expo;
        pend_weight_q <= ev_or.weight;
        pend_minus_q  <= ev_or.minus;
      end
      if (term || done) begin
        out_present_q <= pend_v_q;
        out_expo_q    <= pend_v_q ? pend_expo_q : '0;
        out_weight_q  <= pend_v_q ? pend_weight_q : '0;
        out_minus_q   <= pend_v_q && pend_minus_q;
        out_last_q    <= done;
      end
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.present  = out_present_q;
  assign out_o.exponent = out_expo_q;
  assign out_o.weight   = out_weight_q;
  assign out_o.minus    = out_minus_q;
  assign out_o.last     = out_last_q;

`ifndef SYNTHESIS
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({act_vec, tail_q}))
    else $error("more than one token in the digit row");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (act_vec == '0) && !tail_q && !pend_v_q)
    else $error("token or pending term while idle");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_present_q |-> out_last_q)
    else $error("empty result without last");

  a_single_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(term && done))
    else $error("term and end of scan in the same cycle");
`endif

endmodule
